FILE: rtl/uvs_pkg.sv
// Shared types, codes and constants of the UV sphere vertex and index generator.
`default_nettype none

package uvs_pkg;

    localparam int DIV_STAGES = 8;
    localparam int DIV_BITS   = 4;
    localparam int QUO_W      = DIV_STAGES * DIV_BITS + 1;

    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

    localparam logic [31:0] ATAN_TURNS [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    localparam logic MODE_VERTEX = 1'b0;
    localparam logic MODE_QUAD   = 1'b1;

    localparam logic CFG_SLICE_COUNT = 1'b0;
    localparam logic CFG_STACK_COUNT = 1'b1;

    localparam logic [8:0] CFG_RESET   = 9'd16;
    localparam logic [2:0] LAST_CORNER = 3'd5;

    typedef struct packed {
        logic       mode;
        logic [7:0] stack_row;
        logic [8:0] slice_col;
    } t_req;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] tan_x;
        logic signed [15:0] tan_z;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic [16:0]        vertex_index;
        logic               last;
        logic               bad_request;
    } t_res;

    typedef struct packed {
        logic        mode;
        logic        bad;
        logic [8:0]  a;
        logic [17:0] c;
        logic [17:0] d;
    } t_idx;

    typedef struct packed {
        t_idx               idx;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] tan_x;
        logic signed [15:0] tan_z;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
    } t_item;

endpackage

`default_nettype wire

FILE: rtl/uvs_div.sv
// Pipelined restoring divider: (num << 32) / den, four quotient bits per stage, plus the integer bit in the first.
`default_nettype none

module uvs_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [8:0]                i_num,
    input  wire logic [8:0]                i_den,
    output logic      [uvs_pkg::QUO_W-1:0] o_quo
);

    logic [8:0]                r_rem [uvs_pkg::DIV_STAGES];
    logic [8:0]                r_den [uvs_pkg::DIV_STAGES];
    logic [uvs_pkg::QUO_W-1:0] r_quo [uvs_pkg::DIV_STAGES];

    for (genvar g = 0; g < uvs_pkg::DIV_STAGES; g++) begin : g_stage
        logic [8:0]                rem_in;
        logic [8:0]                den_in;
        logic [uvs_pkg::QUO_W-1:0] quo_in;
        logic [8:0]                n_rem;
        logic [uvs_pkg::QUO_W-1:0] n_quo;

        if (g == 0) begin : g_first
            logic ge_top;
            assign ge_top = (i_num >= i_den);
            assign den_in = i_den;
            assign rem_in = ge_top ? (i_num - i_den) : i_num;
            assign quo_in = {{(uvs_pkg::QUO_W-1){1'b0}}, ge_top};
        end else begin : g_next
            assign den_in = r_den[g-1];
            assign rem_in = r_rem[g-1];
            assign quo_in = r_quo[g-1];
        end

        always_comb begin
            logic [9:0] rem2;
            logic       ge;
            n_rem = rem_in;
            n_quo = quo_in;
            for (int b = 0; b < uvs_pkg::DIV_BITS; b++) begin
                rem2  = {n_rem, 1'b0};
                ge    = (rem2 >= {1'b0, den_in});
                n_rem = ge ? 9'(rem2 - {1'b0, den_in}) : rem2[8:0];
                n_quo = {n_quo[uvs_pkg::QUO_W-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_rem;
                r_den[g] <= den_in;
                r_quo[g] <= n_quo;
            end
        end
    end

    assign o_quo = r_quo[uvs_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/uvs_cordic.sv
// Pipelined rotation-mode CORDIC: cosine and sine in Q1.30 of a 32-bit binary angle.
`default_nettype none

module uvs_cordic #(
    parameter int STEPS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [31:0]        i_ang,
    output logic      signed [33:0] o_cos,
    output logic      signed [33:0] o_sin
);

    localparam int NSTG = (STEPS + 1) / 2;

    logic [31:0]        ang_plus;
    logic [1:0]         quad_w;
    logic [31:0]        resid_w;
    logic [1:0]         r_q0;
    logic signed [33:0] r_z0;

    logic signed [33:0] r_x [NSTG];
    logic signed [33:0] r_y [NSTG];
    logic signed [33:0] r_z [NSTG];
    logic [1:0]         r_q [NSTG];

    logic signed [33:0] r_cos;
    logic signed [33:0] r_sin;

    assign ang_plus = i_ang + 32'h2000_0000;
    assign quad_w   = ang_plus[31:30];
    assign resid_w  = i_ang - {quad_w, 30'd0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q0 <= quad_w;
            r_z0 <= 34'(signed'(resid_w));
        end
    end

    for (genvar g = 0; g < NSTG; g++) begin : g_iter
        logic signed [33:0] x_in;
        logic signed [33:0] y_in;
        logic signed [33:0] z_in;
        logic [1:0]         q_in;
        logic signed [33:0] n_x;
        logic signed [33:0] n_y;
        logic signed [33:0] n_z;

        if (g == 0) begin : g_first
            assign x_in = uvs_pkg::GAIN_Q30;
            assign y_in = '0;
            assign z_in = r_z0;
            assign q_in = r_q0;
        end else begin : g_next
            assign x_in = r_x[g-1];
            assign y_in = r_y[g-1];
            assign z_in = r_z[g-1];
            assign q_in = r_q[g-1];
        end

        always_comb begin
            logic signed [33:0] dx;
            logic signed [33:0] dy;
            logic signed [33:0] at;
            n_x = x_in;
            n_y = y_in;
            n_z = z_in;
            for (int k = 0; k < 2; k++) begin
                if (2 * g + k < STEPS) begin
                    dx = n_y >>> (2 * g + k);
                    dy = n_x >>> (2 * g + k);
                    at = signed'({2'b00, uvs_pkg::ATAN_TURNS[2 * g + k]});
                    if (n_z >= 0) begin
                        n_x = n_x - dx;
                        n_y = n_y + dy;
                        n_z = n_z - at;
                    end else begin
                        n_x = n_x + dx;
                        n_y = n_y - dy;
                        n_z = n_z + at;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g] <= n_x;
                r_y[g] <= n_y;
                r_z[g] <= n_z;
                r_q[g] <= q_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            unique case (r_q[NSTG-1])
                2'd0: begin
                    r_cos <= r_x[NSTG-1];
                    r_sin <= r_y[NSTG-1];
                end
                2'd1: begin
                    r_cos <= -r_y[NSTG-1];
                    r_sin <= r_x[NSTG-1];
                end
                2'd2: begin
                    r_cos <= -r_x[NSTG-1];
                    r_sin <= -r_y[NSTG-1];
                end
                default: begin
                    r_cos <= r_y[NSTG-1];
                    r_sin <= -r_x[NSTG-1];
                end
            endcase
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

`default_nettype wire

FILE: rtl/uvs_out.sv
// Output register: one result for a vertex or bad request, six corners for a quad.
`default_nettype none

module uvs_out (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire uvs_pkg::t_item i_item,
    output logic               o_take,
    output logic               o_valid,
    input  wire logic          i_ready,
    output uvs_pkg::t_res      o_res
);

    logic           r_full;
    logic [2:0]     r_cnt;
    uvs_pkg::t_item r_item;

    logic           last_now;
    logic [8:0]     corner_a;
    logic [17:0]    corner_base;
    logic [17:0]    corner_sum;

    assign last_now = r_item.idx.bad || (r_item.idx.mode == uvs_pkg::MODE_VERTEX) ||
                      (r_cnt == uvs_pkg::LAST_CORNER);
    assign o_take   = !r_full || (i_ready && last_now);
    assign o_valid  = r_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_cnt  <= '0;
        end else if (o_take) begin
            r_full <= i_valid;
            r_cnt  <= '0;
        end else if (i_ready) begin
            r_cnt <= r_cnt + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_item <= i_item;
        end
    end

    always_comb begin
        unique case (r_cnt)
            3'd0: begin corner_a = r_item.idx.a;        corner_base = r_item.idx.c; end
            3'd1: begin corner_a = r_item.idx.a + 9'd1; corner_base = r_item.idx.c; end
            3'd2: begin corner_a = r_item.idx.a;        corner_base = r_item.idx.d; end
            3'd3: begin corner_a = r_item.idx.a + 9'd1; corner_base = r_item.idx.c; end
            3'd4: begin corner_a = r_item.idx.a + 9'd1; corner_base = r_item.idx.d; end
            3'd5: begin corner_a = r_item.idx.a;        corner_base = r_item.idx.d; end
            default: begin corner_a = r_item.idx.a;     corner_base = r_item.idx.c; end
        endcase
    end

    assign corner_sum = {9'd0, corner_a} + corner_base;

    always_comb begin
        o_res = '0;
        if (r_item.idx.bad) begin
            o_res.last        = 1'b1;
            o_res.bad_request = 1'b1;
        end else if (r_item.idx.mode == uvs_pkg::MODE_VERTEX) begin
            o_res.pos_x = r_item.pos_x;
            o_res.pos_y = r_item.pos_y;
            o_res.pos_z = r_item.pos_z;
            o_res.tan_x = r_item.tan_x;
            o_res.tan_z = r_item.tan_z;
            o_res.tex_u = r_item.tex_u;
            o_res.tex_v = r_item.tex_v;
            o_res.last  = 1'b1;
        end else begin
            o_res.vertex_index = corner_sum[16:0];
            o_res.last         = (r_cnt == uvs_pkg::LAST_CORNER);
        end
    end

    a_cnt_quad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 3'd0) |-> (r_full && r_item.idx.mode == uvs_pkg::MODE_QUAD &&
                             !r_item.idx.bad))
        else $error("corner count runs on an item that is not a good quad");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= uvs_pkg::LAST_CORNER)
        else $error("corner count past last corner");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_res.last) |=> (r_cnt == 3'd0))
        else $error("corner count not cleared after last result");

endmodule

`default_nettype wire

FILE: rtl/uv_sphere_vertex_index_gen_core.sv
// Top level of the UV sphere vertex and quad index generator.
// Usage:
//   Requests enter on i_valid/o_ready with payload i_req; results leave on
//   o_valid/i_ready with payload o_res. A vertex request (mode 0) gives one
//   result; a quad request (mode 1) gives six corner indices, the sixth with
//   last set; an out-of-range request gives one result with bad_request set.
//   Slice and stack counts are written through i_cfg_we/i_cfg_idx/i_cfg_data
//   while no request is in flight; both reset to 16.
//   Between acceptance and the first result lie one entry stage, eight
//   divider stages at four quotient bits each, a CORDIC of two iterations per
//   stage plus quadrant reduction and rotation, one multiply stage and the
//   output register. One request is taken per cycle while the pipeline is not
//   held; a quad holds the output register until its sixth corner is taken,
//   and its successor waits behind it until then.
//   When the receiver stalls, the whole pipeline holds and o_ready drops;
//   nothing is lost or repeated. Reset empties the pipeline and restores the
//   configuration.
`default_nettype none

module uv_sphere_vertex_index_gen_core #(
    parameter int MAX_SLICES   = 256,
    parameter int MAX_STACKS   = 256,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire uvs_pkg::t_req i_req,
    output logic               o_valid,
    input  wire logic          i_ready,
    output uvs_pkg::t_res      o_res,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_idx,
    input  wire logic [8:0]    i_cfg_data
);

    localparam int NSTG = (CORDIC_STEPS + 1) / 2;
    localparam int CLAT = NSTG + 2;
    localparam int DSTG = uvs_pkg::DIV_STAGES;

    typedef struct packed {
        uvs_pkg::t_idx idx;
        logic [15:0]   u;
        logic [15:0]   v;
    } t_side;

    function automatic logic signed [15:0] sat16(input logic signed [22:0] v);
        logic signed [15:0] r;
        if (v > 23'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -23'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

    function automatic logic signed [15:0] rnd_q30(input logic signed [34:0] v);
        logic signed [35:0] t;
        t = 36'(v) + 36'sd16384;
        return sat16(23'(t >>> 15));
    endfunction

    function automatic logic signed [15:0] rnd_prod(input logic signed [67:0] p);
        logic signed [67:0] t;
        t = p + 68'sd17592186044416;
        return sat16(23'(t >>> 45));
    endfunction

    logic           en;
    logic [8:0]     r_slice_cfg;
    logic [8:0]     r_stack_cfg;

    logic [10:0]    slc_w;
    logic [10:0]    stk_w;
    logic [8:0]     slices;
    logic [8:0]     stacks;
    logic [9:0]     step_w;
    logic [17:0]    c_w;
    logic           bad_w;
    uvs_pkg::t_idx  idx_w;

    logic           r_e_valid;
    uvs_pkg::t_idx  r_e_idx;
    logic [8:0]     r_e_s;
    logic [8:0]     r_e_t;
    logic [8:0]     r_e_dphi;
    logic [8:0]     r_e_dth;
    logic [8:0]     r_e_dv;

    logic [uvs_pkg::QUO_W-1:0] q_phi;
    logic [uvs_pkg::QUO_W-1:0] q_th;
    logic [uvs_pkg::QUO_W-1:0] q_v;

    logic           r_v1 [DSTG];
    uvs_pkg::t_idx  r_s1 [DSTG];
    logic           r_v2 [CLAT];
    t_side          r_s2 [CLAT];
    t_side          side_w;

    logic signed [33:0] cos_phi;
    logic signed [33:0] sin_phi;
    logic signed [33:0] cos_th;
    logic signed [33:0] sin_th;
    logic signed [33:0] sp_c;

    logic               r_m_valid;
    t_side              r_m_side;
    logic signed [67:0] r_px;
    logic signed [67:0] r_pz;
    logic signed [33:0] r_cp;
    logic signed [33:0] r_st;
    logic signed [33:0] r_ct;

    uvs_pkg::t_item     item_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_cfg <= uvs_pkg::CFG_RESET;
            r_stack_cfg <= uvs_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                uvs_pkg::CFG_SLICE_COUNT: r_slice_cfg <= i_cfg_data;
                uvs_pkg::CFG_STACK_COUNT: r_stack_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_slice_cfg == 9'd0) begin
            slc_w = 11'd1;
        end else if ({2'b00, r_slice_cfg} > 11'(MAX_SLICES)) begin
            slc_w = 11'(MAX_SLICES);
        end else begin
            slc_w = {2'b00, r_slice_cfg};
        end
        if (r_stack_cfg < 9'd2) begin
            stk_w = 11'd2;
        end else if ({2'b00, r_stack_cfg} > 11'(MAX_STACKS)) begin
            stk_w = 11'(MAX_STACKS);
        end else begin
            stk_w = {2'b00, r_stack_cfg};
        end
    end

    assign slices = slc_w[8:0];
    assign stacks = stk_w[8:0];
    assign step_w = {1'b0, slices} + 10'd1;
    assign c_w    = 18'(i_req.stack_row) * 18'(step_w);

    always_comb begin
        if (i_req.mode == uvs_pkg::MODE_VERTEX) begin
            bad_w = ({1'b0, i_req.stack_row} >= stacks) || (i_req.slice_col > slices);
        end else begin
            bad_w = (({1'b0, i_req.stack_row} + 9'd1) >= stacks) ||
                    (i_req.slice_col >= slices);
        end
        idx_w.mode = i_req.mode;
        idx_w.bad  = bad_w;
        idx_w.a    = i_req.slice_col;
        idx_w.c    = c_w;
        idx_w.d    = c_w + 18'(step_w);
    end

    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (en) begin
            r_e_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_idx  <= idx_w;
            r_e_s    <= {1'b0, i_req.stack_row};
            r_e_t    <= i_req.slice_col;
            r_e_dphi <= stacks - 9'd1;
            r_e_dth  <= slices;
            r_e_dv   <= stacks;
        end
    end

    uvs_div u_div_phi (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_e_s),
        .i_den (r_e_dphi),
        .o_quo (q_phi)
    );

    uvs_div u_div_theta (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_e_t),
        .i_den (r_e_dth),
        .o_quo (q_th)
    );

    uvs_div u_div_v (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_e_s),
        .i_den (r_e_dv),
        .o_quo (q_v)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DSTG; k++) begin
                r_v1[k] <= 1'b0;
            end
        end else if (en) begin
            r_v1[0] <= r_e_valid;
            for (int k = 1; k < DSTG; k++) begin
                r_v1[k] <= r_v1[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1[0] <= r_e_idx;
            for (int k = 1; k < DSTG; k++) begin
                r_s1[k] <= r_s1[k-1];
            end
        end
    end

    uvs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_phi (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ang (q_phi[32:1]),
        .o_cos (cos_phi),
        .o_sin (sin_phi)
    );

    uvs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_theta (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ang (q_th[31:0]),
        .o_cos (cos_th),
        .o_sin (sin_th)
    );

    assign side_w.idx = r_s1[DSTG-1];
    assign side_w.u   = q_th[32:17];
    assign side_w.v   = q_v[32:17];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CLAT; k++) begin
                r_v2[k] <= 1'b0;
            end
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_v2[0] <= r_v1[DSTG-1];
            for (int k = 1; k < CLAT; k++) begin
                r_v2[k] <= r_v2[k-1];
            end
            r_m_valid <= r_v2[CLAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2[0] <= side_w;
            for (int k = 1; k < CLAT; k++) begin
                r_s2[k] <= r_s2[k-1];
            end
        end
    end

    assign sp_c = (sin_phi < 0) ? 34'sd0 : sin_phi;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_side <= r_s2[CLAT-1];
            r_px     <= sp_c * cos_th;
            r_pz     <= sp_c * sin_th;
            r_cp     <= cos_phi;
            r_st     <= sin_th;
            r_ct     <= cos_th;
        end
    end

    always_comb begin
        item_w.idx   = r_m_side.idx;
        item_w.pos_x = rnd_prod(r_px);
        item_w.pos_y = rnd_q30(35'(r_cp));
        item_w.pos_z = rnd_prod(r_pz);
        item_w.tan_x = rnd_q30(-35'(r_st));
        item_w.tan_z = rnd_q30(35'(r_ct));
        item_w.tex_u = r_m_side.u;
        item_w.tex_v = r_m_side.v;
    end

    uvs_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_m_valid),
        .i_item  (item_w),
        .o_take  (en),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire
